// File: src/sjfa_pkg.sv
// ----------------------------------------------------------------------------
// sjfa_pkg
// Shared types and codes of the multilevel SJF scheduler with aging.
// ----------------------------------------------------------------------------
package sjfa_pkg;

	localparam int ID_W     = 16;
	localparam int LVL_W    = 3;
	localparam int BURST_W  = 16;
	localparam int STAT_W   = 3;
	localparam int TIME_W   = 32;
	localparam int PERIOD_W = 16;

	localparam logic [PERIOD_W-1:0] AGING_RESET = 16'd10;

	localparam logic [STAT_W-1:0] STAT_ADDED  = 3'd0;
	localparam logic [STAT_W-1:0] STAT_RAN    = 3'd1;
	localparam logic [STAT_W-1:0] STAT_IDLE   = 3'd2;
	localparam logic [STAT_W-1:0] STAT_BADLVL = 3'd3;
	localparam logic [STAT_W-1:0] STAT_FULL   = 3'd4;

	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_TICK   = 2'd1;
	localparam logic [1:0] OP_BADLVL = 2'd2;

	typedef struct packed {
		logic [1:0]         op;
		logic [ID_W-1:0]    job_id;
		logic [LVL_W-1:0]   level;
		logic [BURST_W-1:0] burst;
	} item_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [ID_W-1:0]    ran_id;
		logic [BURST_W-1:0] remaining;
		logic               finished;
		logic [BURST_W-1:0] total_work;
		logic [TIME_W-1:0]  wait_time;
		logic               promoted;
		logic [ID_W-1:0]    promoted_id;
		logic [LVL_W-1:0]   promoted_level;
	} result_t;

endpackage

// File: src/sjfa_front.sv
// ----------------------------------------------------------------------------
// sjfa_front
// Accepts request transactions, classifies them and queues them (two entries)
// for the scheduling engine.
// ----------------------------------------------------------------------------
module sjfa_front import sjfa_pkg::*; #(
	parameter int LEVELS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               req_type,
	input  logic [ID_W-1:0]    job_id,
	input  logic [LVL_W-1:0]   level,
	input  logic [BURST_W-1:0] burst,
	output logic               q_valid,
	input  logic               q_ready,
	output item_t              q_item
);

	item_t      buf_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;
	item_t      item;

	always_comb begin
		item.job_id = job_id;
		item.level  = level;
		item.burst  = burst;
		if (req_type) begin
			item.op = OP_TICK;
		end else if ({1'b0, level} >= 4'(LEVELS)) begin
			item.op = OP_BADLVL;
		end else begin
			item.op = OP_ADD;
		end
	end

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = buf_q[rd_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= item;
		end
	end

endmodule

// File: src/sjfa_back.sv
// ----------------------------------------------------------------------------
// sjfa_back
// Scheduling engine: holds the job table and carries out one queued request
// at a time; adds and ticks sweep the table one entry per cycle.
// ----------------------------------------------------------------------------
module sjfa_back import sjfa_pkg::*; #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [PERIOD_W-1:0] period,
	input  logic                cfg_we,
	input  logic                q_valid,
	output logic                q_ready,
	input  item_t               q_item,
	output logic                res_valid,
	input  logic                res_ready,
	output result_t             res
);

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_ADD  = 3'd2;
	localparam logic [2:0] ST_RUN  = 3'd3;
	localparam logic [2:0] ST_UPD  = 3'd4;
	localparam logic [2:0] ST_AGE  = 3'd5;
	localparam logic [2:0] ST_PRO  = 3'd6;
	localparam logic [2:0] ST_OUT  = 3'd7;

	logic [TABLE_DEPTH-1:0] e_vld_q;
	logic [ID_W-1:0]        e_id_q    [TABLE_DEPTH];
	logic [LVL_W-1:0]       e_lvl_q   [TABLE_DEPTH];
	logic [BURST_W-1:0]     e_rem_q   [TABLE_DEPTH];
	logic [BURST_W-1:0]     e_tot_q   [TABLE_DEPTH];
	logic [TIME_W-1:0]      e_stamp_q [TABLE_DEPTH];

	logic [2:0]          state_q;
	logic [IW-1:0]       idx_q;
	logic                found_q;
	logic [IW-1:0]       best_q;
	logic [LVL_W-1:0]    best_lvl_q;
	logic [BURST_W-1:0]  best_rem_q;
	logic [TIME_W-1:0]   best_age_q;
	logic [ID_W-1:0]     best_id_q;
	logic [BURST_W-1:0]  best_tot_q;
	logic [TIME_W-1:0]   stamp_q;
	logic [TIME_W-1:0]   elapsed_q;
	logic [PERIOD_W-1:0] rem_q;
	logic                div_pend_q;
	logic [4:0]          div_cnt_q;
	item_t               item_q;
	result_t             res_q;

	logic                last;
	logic                cur_vld;
	logic [LVL_W-1:0]    cur_lvl;
	logic [BURST_W-1:0]  cur_rem;
	logic [TIME_W-1:0]   cur_age;
	logic                lvl_eq;
	logic                rem_eq;
	logic                age_lt;
	logic                run_better;
	logic                age_better;
	logic                take_run;
	logic                take_age;
	logic                take;
	logic [PERIOD_W:0]   div_sh;
	logic [PERIOD_W-1:0] rem_inc;
	logic [PERIOD_W-1:0] rem_next;
	logic [TIME_W-1:0]   elapsed_inc;
	logic                retire;
	result_t             res_init;

	assign last    = (idx_q == IW'(TABLE_DEPTH - 1));
	assign cur_vld = e_vld_q[idx_q];
	assign cur_lvl = e_lvl_q[idx_q];
	assign cur_rem = e_rem_q[idx_q];
	assign cur_age = stamp_q - e_stamp_q[idx_q];
	assign lvl_eq  = (cur_lvl == best_lvl_q);
	assign rem_eq  = (cur_rem == best_rem_q);
	assign age_lt  = (cur_age < best_age_q);

	assign run_better = (cur_lvl < best_lvl_q) ||
		(lvl_eq && ((cur_rem < best_rem_q) || (rem_eq && age_lt)));
	assign age_better = (cur_lvl > best_lvl_q) ||
		(lvl_eq && ((cur_rem > best_rem_q) || (rem_eq && age_lt)));
	assign take_run = cur_vld && (!found_q || run_better);
	assign take_age = cur_vld && (cur_lvl != '0) && (!found_q || age_better);
	assign take     = (state_q == ST_RUN) ? take_run : take_age;

	assign div_sh      = {rem_q, elapsed_q[~div_cnt_q]};
	assign rem_inc     = rem_q + 16'd1;
	assign rem_next    = (rem_inc == period) ? '0 : rem_inc;
	assign elapsed_inc = elapsed_q + 32'd1;
	assign retire      = (best_rem_q <= 16'd1);

	assign q_ready   = (state_q == ST_IDLE) && !cfg_we && !div_pend_q;
	assign res_valid = (state_q == ST_OUT);
	assign res       = res_q;

	always_comb begin
		res_init = '0;
		if (q_item.op == OP_BADLVL) begin
			res_init.status = STAT_BADLVL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			e_vld_q    <= '0;
			idx_q      <= '0;
			found_q    <= 1'b0;
			stamp_q    <= '0;
			elapsed_q  <= '0;
			rem_q      <= '0;
			div_pend_q <= 1'b0;
			div_cnt_q  <= '0;
		end else begin
			if (cfg_we) begin
				div_pend_q <= 1'b1;
			end else if (state_q == ST_IDLE) begin
				div_pend_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					idx_q   <= '0;
					found_q <= 1'b0;
					if (cfg_we || div_pend_q) begin
						if (!cfg_we) begin
							div_cnt_q <= '0;
							rem_q     <= '0;
							if (period != '0) begin
								state_q <= ST_DIV;
							end
						end
					end else if (q_valid) begin
						case (q_item.op)
							OP_ADD:  state_q <= ST_ADD;
							OP_TICK: state_q <= ST_RUN;
							default: state_q <= ST_OUT;
						endcase
					end
				end
				ST_DIV: begin
					if (div_sh >= {1'b0, period}) begin
						rem_q <= PERIOD_W'(div_sh - {1'b0, period});
					end else begin
						rem_q <= div_sh[PERIOD_W-1:0];
					end
					div_cnt_q <= div_cnt_q + 5'd1;
					if (div_cnt_q == 5'd31) begin
						state_q <= ST_IDLE;
					end
				end
				ST_ADD: begin
					if (!cur_vld) begin
						e_vld_q[idx_q] <= 1'b1;
						stamp_q        <= stamp_q + 32'd1;
						state_q        <= ST_OUT;
					end else if (last) begin
						state_q <= ST_OUT;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				ST_RUN, ST_AGE: begin
					if (take) begin
						found_q <= 1'b1;
					end
					idx_q <= idx_q + IW'(1);
					if (last) begin
						if (state_q == ST_RUN) begin
							state_q <= (found_q || take) ? ST_UPD : ST_OUT;
						end else begin
							state_q <= (found_q || take) ? ST_PRO : ST_OUT;
						end
					end
				end
				ST_UPD: begin
					elapsed_q <= elapsed_inc;
					rem_q     <= rem_next;
					idx_q     <= '0;
					found_q   <= 1'b0;
					if (retire) begin
						e_vld_q[best_q] <= 1'b0;
					end
					if ((period != '0) && (rem_next == '0)) begin
						state_q <= ST_AGE;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_PRO: begin
					stamp_q <= stamp_q + 32'd1;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (q_ready && q_valid) begin
					item_q <= q_item;
					res_q  <= res_init;
				end
			end
			ST_ADD: begin
				if (!cur_vld) begin
					e_id_q[idx_q]    <= item_q.job_id;
					e_lvl_q[idx_q]   <= item_q.level;
					e_rem_q[idx_q]   <= item_q.burst;
					e_tot_q[idx_q]   <= item_q.burst;
					e_stamp_q[idx_q] <= stamp_q;
					res_q.status     <= STAT_ADDED;
				end else begin
					res_q.status <= STAT_FULL;
				end
			end
			ST_RUN, ST_AGE: begin
				if (take) begin
					best_q     <= idx_q;
					best_lvl_q <= cur_lvl;
					best_rem_q <= cur_rem;
					best_age_q <= cur_age;
					best_id_q  <= e_id_q[idx_q];
					best_tot_q <= e_tot_q[idx_q];
				end
				if (state_q == ST_RUN) begin
					res_q.status <= STAT_IDLE;
				end
			end
			ST_UPD: begin
				res_q.status <= STAT_RAN;
				res_q.ran_id <= best_id_q;
				if (retire) begin
					e_rem_q[best_q]  <= '0;
					res_q.remaining  <= '0;
					res_q.finished   <= 1'b1;
					res_q.total_work <= best_tot_q;
					res_q.wait_time  <= elapsed_inc - {16'd0, best_tot_q};
				end else begin
					e_rem_q[best_q] <= best_rem_q - 16'd1;
					res_q.remaining <= best_rem_q - 16'd1;
				end
			end
			ST_PRO: begin
				e_lvl_q[best_q]      <= best_lvl_q - 3'd1;
				e_stamp_q[best_q]    <= stamp_q;
				res_q.promoted       <= 1'b1;
				res_q.promoted_id    <= best_id_q;
				res_q.promoted_level <= best_lvl_q - 3'd1;
			end
			default: begin
			end
		endcase
	end

endmodule

// File: src/multilevel_sjf_scheduler_with_aging_unit.sv
// ----------------------------------------------------------------------------
// multilevel_sjf_scheduler_with_aging_unit
// Multilevel shortest-job-first scheduler with aging promotions.
// ----------------------------------------------------------------------------
// Channel  Handshake            Carries
// in       in_valid/in_ready    req_type, job_id, level, burst
// out      out_valid/out_ready  status, ran_id, remaining, finished, total_work,
//                               wait_time, promoted, promoted_id, promoted_level
// cfg      cfg_valid/cfg_ready  cfg_data (aging period)
//
// Add: a free-slot sweep of the table. Invalid level: answered without a sweep.
// Tick: a table sweep for the job to run, plus a second sweep when a promotion
// is due; both sweeps take one table entry per cycle.
// A configuration write holds requests while the remainder of elapsed ticks
// by the new period is rebuilt serially.
// Reset clears the table valid bits and counters and sets the aging period to 10.
// A two-entry request queue and the output register decouple stalls.
// ----------------------------------------------------------------------------
module multilevel_sjf_scheduler_with_aging_unit import sjfa_pkg::*; #(
	parameter int LEVELS      = 4,
	parameter int TABLE_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                req_type,
	input  logic [ID_W-1:0]     job_id,
	input  logic [LVL_W-1:0]    level,
	input  logic [BURST_W-1:0]  burst,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STAT_W-1:0]   status,
	output logic [ID_W-1:0]     ran_id,
	output logic [BURST_W-1:0]  remaining,
	output logic                finished,
	output logic [BURST_W-1:0]  total_work,
	output logic [TIME_W-1:0]   wait_time,
	output logic                promoted,
	output logic [ID_W-1:0]     promoted_id,
	output logic [LVL_W-1:0]    promoted_level,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [PERIOD_W-1:0] cfg_data
);

	logic [PERIOD_W-1:0] period_q;
	logic                cfg_we;
	logic                q_valid;
	logic                q_ready;
	item_t               q_item;
	logic                res_valid;
	logic                res_ready;
	result_t             res;
	logic                out_valid_q;
	result_t             out_q;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign res_ready = !out_valid_q || out_ready;

	sjfa_front #(
		.LEVELS (LEVELS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.req_type (req_type),
		.job_id   (job_id),
		.level    (level),
		.burst    (burst),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_item   (q_item)
	);

	sjfa_back #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.period    (period_q),
		.cfg_we    (cfg_we),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_item    (q_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= AGING_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				period_q <= cfg_data;
			end
			if (res_valid && res_ready) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_q.status;
	assign ran_id         = out_q.ran_id;
	assign remaining      = out_q.remaining;
	assign finished       = out_q.finished;
	assign total_work     = out_q.total_work;
	assign wait_time      = out_q.wait_time;
	assign promoted       = out_q.promoted;
	assign promoted_id    = out_q.promoted_id;
	assign promoted_level = out_q.promoted_level;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("engine result dropped while stalled");

	a_cfg_blocks_pop: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !(q_valid && q_ready))
		else $error("request taken during aging remainder update");

	a_flags_need_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != STAT_RAN) |-> !finished && !promoted)
		else $error("run flags set on a non-run result");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready |=> !res_valid)
		else $error("engine issued two results for one request");

endmodule
